/* rtl/core/fud_pkg.sv */
`default_nettype none

package fud_pkg;

	// Largest supported destination size and the count width it needs
	localparam int MAX_BUFFER_SIZE_DEF = 64;
	localparam int CNT_W               = 6;
	localparam int QUEUE_DEPTH_DEF     = 2;

	// Configuration and payload widths
	localparam int CFG_W  = 7;
	localparam int BYTE_W = 8;

	localparam logic [CFG_W-1:0] BUFFER_SIZE_RST = 7'd33;

	// Characters with a meaning of their own
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	// Work for the back end: a run of flushed spaces, then up to three bytes
	typedef struct packed {
		logic [CNT_W-1:0]             spaces;
		logic [1:0]                   nb;
		logic [2:0][BYTE_W-1:0]       bytes;
		logic                         last;
	} fud_cmd_t;

	// Decode one hex digit: valid flag over the 4-bit value
	function automatic logic [4:0] hex_digit(logic [BYTE_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/fud_if.sv */
`default_nettype none

// Character items into the decoder
interface fud_char_if;
	import fud_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// Decoded result items
interface fud_res_if;
	import fud_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              has_byte;
	logic              last;

	modport source (output valid, output out_byte, output has_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input last, output ready);
endinterface

// Write channel for the buffer size register
interface fud_cfg_if;
	import fud_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] buffer_size;

	modport source (output valid, output buffer_size, input ready);
	modport sink   (input valid, input buffer_size, output ready);
endinterface

`default_nettype wire

/* rtl/core/fud_front.sv */
`default_nettype none

module fud_front #(
	parameter int MAX_BUFFER_SIZE = fud_pkg::MAX_BUFFER_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fud_char_if.sink        chars,
	fud_cfg_if.sink         cfg,
	output fud_pkg::fud_cmd_t push_data,
	output logic            push_valid,
	input  wire logic       push_ready
);
	import fud_pkg::*;

	localparam logic [CFG_W-1:0] MAX_BS = CFG_W'(MAX_BUFFER_SIZE);

	typedef enum logic [2:0] {
		ESC_NONE = 3'b001,
		ESC_PCT  = 3'b010,
		ESC_DIG  = 3'b100
	} fud_esc_t;

	// Running counts and the command being built for one item
	typedef struct packed {
		logic [CNT_W-1:0]       em;
		logic [CNT_W-1:0]       pend;
		logic [CNT_W-1:0]       spaces;
		logic [1:0]             nb;
		logic [2:0][BYTE_W-1:0] bytes;
		logic                   esc;
	} fud_acc_t;

	logic [CFG_W-1:0]  bs_q;
	logic [CNT_W-1:0]  em_q, pend_q;
	fud_esc_t          phase_q, phase_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic [CNT_W-1:0]  limit;
	logic [CFG_W-1:0]  bs_clamped;
	fud_acc_t          acc;
	logic [4:0]        hx_c, hx_h;
	logic              accept;

	function automatic logic room(fud_acc_t a, logic [CNT_W-1:0] lim);
		return ({1'b0, a.em} + {1'b0, a.pend}) < {1'b0, lim};
	endfunction

	// Hold a space back, or flush held spaces and write the byte
	function automatic fud_acc_t put_byte(fud_acc_t a, logic [BYTE_W-1:0] b,
			logic [CNT_W-1:0] lim);
		fud_acc_t r;
		r = a;
		if (room(a, lim)) begin
			if (b == CH_SPACE) begin
				r.pend = CNT_W'(a.pend + 1'b1);
			end else begin
				r.spaces       = CNT_W'(a.spaces + a.pend);
				r.em           = CNT_W'(a.em + a.pend + 1'b1);
				r.pend         = '0;
				r.bytes[a.nb]  = b;
				r.nb           = 2'(a.nb + 1'b1);
			end
		end
		return r;
	endfunction

	function automatic fud_acc_t plain_char(fud_acc_t a, logic [BYTE_W-1:0] c,
			logic [CNT_W-1:0] lim);
		fud_acc_t r;
		r = a;
		if (c == CH_PLUS) begin
			r = put_byte(a, CH_SPACE, lim);
		end else if (c == CH_PCT) begin
			r.esc = room(a, lim);
		end else begin
			r = put_byte(a, c, lim);
		end
		return r;
	endfunction

	// Clamp the size and derive the output limit
	always_comb begin
		bs_clamped = (bs_q > MAX_BS) ? MAX_BS : bs_q;
		limit      = (bs_clamped == '0) ? '0 : CNT_W'(bs_clamped - 1'b1);
	end

	assign hx_c = hex_digit(chars.in_byte);
	assign hx_h = hex_digit(held_q);

	// Classify the item and build its command
	always_comb begin
		acc.em     = em_q;
		acc.pend   = pend_q;
		acc.spaces = '0;
		acc.nb     = '0;
		acc.bytes  = '0;
		acc.esc    = 1'b0;
		phase_d    = phase_q;
		held_d     = held_q;
		if (chars.kind) begin
			unique case (phase_q)
				ESC_PCT: begin
					acc = put_byte(acc, CH_PCT, limit);
				end
				ESC_DIG: begin
					acc = put_byte(acc, CH_PCT, limit);
					acc = put_byte(acc, held_q, limit);
				end
				default: begin
				end
			endcase
			phase_d = ESC_NONE;
			held_d  = '0;
		end else begin
			unique case (phase_q)
				ESC_PCT: begin
					if (hx_c[4]) begin
						held_d  = chars.in_byte;
						phase_d = ESC_DIG;
					end else begin
						phase_d = ESC_NONE;
						acc = put_byte(acc, CH_PCT, limit);
						acc = plain_char(acc, chars.in_byte, limit);
					end
				end
				ESC_DIG: begin
					phase_d = ESC_NONE;
					if (hx_h[4] && hx_c[4]) begin
						acc = put_byte(acc, {hx_h[3:0], hx_c[3:0]}, limit);
					end else begin
						acc = put_byte(acc, CH_PCT, limit);
						acc = put_byte(acc, held_q, limit);
						acc = plain_char(acc, chars.in_byte, limit);
					end
					held_d = '0;
				end
				default: begin
					phase_d = ESC_NONE;
					acc = plain_char(acc, chars.in_byte, limit);
				end
			endcase
			if (acc.esc) begin
				phase_d = ESC_PCT;
			end
		end
	end

	assign chars.ready      = push_ready;
	assign cfg.ready        = 1'b1;
	assign accept           = chars.valid && push_ready;
	assign push_valid       = chars.valid && (chars.kind || acc.nb != '0);
	assign push_data.spaces = acc.spaces;
	assign push_data.nb     = acc.nb;
	assign push_data.bytes  = acc.bytes;
	assign push_data.last   = chars.kind;

	// Advance the string state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q    <= BUFFER_SIZE_RST;
			em_q    <= '0;
			pend_q  <= '0;
			phase_q <= ESC_NONE;
			held_q  <= '0;
		end else begin
			if (cfg.valid) begin
				bs_q <= cfg.buffer_size;
			end
			if (accept) begin
				phase_q <= phase_d;
				held_q  <= held_d;
				if (chars.kind) begin
					em_q   <= '0;
					pend_q <= '0;
				end else begin
					em_q   <= acc.em;
					pend_q <= acc.pend;
				end
			end
		end
	end

	// A held digit is always a hex digit
	a_held_hex: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ESC_DIG |-> hx_h[4])
		else $error("held escape digit is not hex");

endmodule

`default_nettype wire

/* rtl/core/fud_queue.sv */
`default_nettype none

module fud_queue #(
	parameter int DEPTH = fud_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fud_pkg::fud_cmd_t push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output fud_pkg::fud_cmd_t      pop_data,
	output logic                   pop_valid,
	input  wire logic              pop
);
	import fud_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

	fud_cmd_t          slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != FULL_CNT;
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CNT_QW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CNT_QW'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("command queue overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> cnt_q != '0)
		else $error("pop from empty command queue");

endmodule

`default_nettype wire

/* rtl/core/fud_back.sv */
`default_nettype none

module fud_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fud_pkg::fud_cmd_t head,
	input  wire logic              head_valid,
	output logic                   pop,
	fud_res_if.source              results
);
	import fud_pkg::*;

	logic [CNT_W-1:0]  sent_q;
	logic [1:0]        bi_q;
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              has_q, last_q;
	logic              fire, in_spaces, fin;
	logic [BYTE_W-1:0] nxt_byte;
	logic              nxt_has, nxt_last;

	// Pick the next result from the head command
	always_comb begin
		in_spaces = sent_q < head.spaces;
		nxt_byte  = CH_SPACE;
		nxt_has   = 1'b1;
		nxt_last  = 1'b0;
		fin       = 1'b0;
		if (!in_spaces) begin
			if (head.nb == '0) begin
				nxt_byte = '0;
				nxt_has  = 1'b0;
				nxt_last = 1'b1;
				fin      = 1'b1;
			end else begin
				case (bi_q)
					2'd0:    nxt_byte = head.bytes[0];
					2'd1:    nxt_byte = head.bytes[1];
					default: nxt_byte = head.bytes[2];
				endcase
				fin      = 2'(bi_q + 1'b1) == head.nb;
				nxt_last = head.last && fin;
			end
		end
	end

	assign fire = head_valid && (!out_v_q || results.ready);
	assign pop  = fire && fin;

	assign results.valid    = out_v_q;
	assign results.out_byte = out_byte_q;
	assign results.has_byte = has_q;
	assign results.last     = last_q;

	// Load the output register; drop it once taken
	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= nxt_byte;
			has_q      <= nxt_has;
			last_q     <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sent_q  <= '0;
			bi_q    <= '0;
		end else begin
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (fire) begin
				if (fin) begin
					sent_q <= '0;
					bi_q   <= '0;
				end else if (in_spaces) begin
					sent_q <= CNT_W'(sent_q + 1'b1);
				end else begin
					bi_q <= 2'(bi_q + 1'b1);
				end
			end
		end
	end

	a_spaces_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> sent_q <= head.spaces)
		else $error("flushed more spaces than held");

	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !nxt_has |-> head.last && head.spaces == '0)
		else $error("bare marker outside an end item");

endmodule

`default_nettype wire

/* rtl/core/form_url_decoder.sv */
// Form-urlencoded decoder.
// chars: one item per encoded character (kind 0, in_byte) or an end item (kind 1).
// results: decoded bytes (has_byte 1) in order; the final result of a string has
// last set, and an end item with nothing to write gives a bare marker (has_byte 0).
// cfg: writes buffer_size, the destination size including terminator; ready is
// always high. Write it only while no string is in flight.
// The first result of an item passes through the command queue, then the output
// register. Throughput: one item per cycle while the command queue (QUEUE_DEPTH
// entries) has room, and one result per cycle while results.ready is high. An
// item that flushes held spaces gives one result per space and per byte; the
// front end keeps accepting until the command queue is full.
// When results.ready is low the output register holds its item, the queue fills
// and chars.ready falls; nothing is lost.
// Reset: buffer_size returns to 33, all string state and the queue are cleared;
// items are accepted as soon as reset is released.
`default_nettype none

module form_url_decoder #(
	parameter int MAX_BUFFER_SIZE = fud_pkg::MAX_BUFFER_SIZE_DEF,
	parameter int QUEUE_DEPTH     = fud_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fud_char_if.sink  chars,
	fud_cfg_if.sink   cfg,
	fud_res_if.source results
);
	import fud_pkg::*;

	fud_cmd_t push_data, head;
	logic     push_valid, push_ready, head_valid, pop;

	// Accept and classify characters
	fud_front #(
		.MAX_BUFFER_SIZE(MAX_BUFFER_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg       (cfg),
		.push_data (push_data),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	// Decouple the two sides
	fud_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_data  (head),
		.pop_valid (head_valid),
		.pop       (pop)
	);

	// Emit results
	fud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.results   (results)
	);

endmodule

`default_nettype wire

/* tb/sv/fud_decode_monitor.sv */
`timescale 1ns / 1ps

package fud_tb_pkg;
	typedef enum logic {KIND_CHAR = 1'b0, KIND_END = 1'b1} char_kind_e;
endpackage

module fud_decode_monitor
	import fud_pkg::*;
	import fud_tb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	input  wire logic              char_ready,
	input  wire logic              char_kind,
	input  wire logic [BYTE_W-1:0] char_byte,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_size,
	input  wire logic              res_valid,
	input  wire logic              res_ready,
	input  wire logic [BYTE_W-1:0] res_byte,
	input  wire logic              res_has_byte,
	input  wire logic              res_last,
	output int                     fail_count,
	output int                     pending_results
);

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              last;
	} decoded_t;

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_e;

	// Mirror of the decoder's register and string state
	logic [CFG_W-1:0]  size_reg;
	logic [CNT_W-1:0]  emitted;
	logic [CNT_W-1:0]  spaces;
	esc_e              esc;
	logic [BYTE_W-1:0] held;
	int                step_n;
	decoded_t          decoded_q[$];

	initial begin
		fail_count      = 0;
		pending_results = 0;
	end

	function automatic int out_limit();
		int sz;
		sz = (size_reg > MAX_BUFFER_SIZE_DEF) ? MAX_BUFFER_SIZE_DEF : int'(size_reg);
		return (sz == 0) ? 0 : sz - 1;
	endfunction

	function automatic bit room();
		return int'(emitted) + int'(spaces) < out_limit();
	endfunction

	function automatic int hex_val(logic [BYTE_W-1:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic emit(logic [BYTE_W-1:0] b);
		decoded_q.push_back(decoded_t'{out_byte: b, has_byte: 1'b1, last: 1'b0});
		step_n++;
	endtask

	// Hold spaces back; flush them ahead of the next other byte
	task automatic put(logic [BYTE_W-1:0] b);
		if (room()) begin
			if (b == CH_SPACE) begin
				spaces++;
			end else begin
				while (spaces != 0) begin
					emit(CH_SPACE);
					spaces--;
					emitted++;
				end
				emit(b);
				emitted++;
			end
		end
	endtask

	task automatic plain(logic [BYTE_W-1:0] c);
		if (c == CH_PLUS) begin
			put(CH_SPACE);
		end else if (c == CH_PCT) begin
			if (room())
				esc = ESC_PCT;
		end else begin
			put(c);
		end
	endtask

	task automatic clear_string();
		emitted = '0;
		spaces  = '0;
		esc     = ESC_NONE;
		held    = '0;
	endtask

	// Work out the results one accepted item causes
	task automatic decode_item(logic k, logic [BYTE_W-1:0] c);
		int       hi;
		int       lo;
		decoded_t tail;
		step_n = 0;
		if (k == KIND_END) begin
			if (esc == ESC_PCT) begin
				put(CH_PCT);
			end else if (esc == ESC_DIGIT) begin
				put(CH_PCT);
				put(held);
			end
			if (step_n > 0) begin
				tail = decoded_q.pop_back();
				tail.last = 1'b1;
				decoded_q.push_back(tail);
			end else begin
				decoded_q.push_back(decoded_t'{out_byte: '0, has_byte: 1'b0, last: 1'b1});
			end
			clear_string();
		end else if (esc == ESC_PCT) begin
			if (hex_val(c) >= 0) begin
				held = c;
				esc  = ESC_DIGIT;
			end else begin
				esc = ESC_NONE;
				put(CH_PCT);
				plain(c);
			end
		end else if (esc == ESC_DIGIT) begin
			hi  = hex_val(held);
			lo  = hex_val(c);
			esc = ESC_NONE;
			if (hi >= 0 && lo >= 0) begin
				put(BYTE_W'((hi << 4) | lo));
			end else begin
				put(CH_PCT);
				put(held);
				plain(c);
			end
			held = '0;
		end else begin
			plain(c);
		end
	endtask

	// Compare results, then take register writes and new items
	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		bit       bad;
		if (!arst_n) begin
			size_reg = BUFFER_SIZE_RST;
			clear_string();
			decoded_q.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h/%b/%b",
						$time, res_byte, res_has_byte, res_last);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					bad  = 0;
					if (want.out_byte !== res_byte) begin
						$display("%0t: out_byte expected %h actual %h",
							$time, want.out_byte, res_byte);
						bad = 1;
					end
					if (want.has_byte !== res_has_byte) begin
						$display("%0t: has_byte expected %b actual %b",
							$time, want.has_byte, res_has_byte);
						bad = 1;
					end
					if (want.last !== res_last) begin
						$display("%0t: last expected %b actual %b",
							$time, want.last, res_last);
						bad = 1;
					end
					if (bad)
						fail_count++;
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = cfg_size;
			if (char_valid && char_ready)
				decode_item(char_kind, char_byte);
		end
		pending_results = decoded_q.size();
	end

endmodule

/* tb/sv/tb_form_url_decoder.sv */
`timescale 1ns / 1ps

module tb_form_url_decoder;
	import fud_pkg::*;
	import fud_tb_pkg::*;

	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int SETTLE_CYCLES     = 8;
	localparam int ITEMS_PER_SETTING = 25;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int pending_results;
	int items_sent   = 0;
	int src_idle     = 0;
	int sink_stall   = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	fud_char_if chars_if ();
	fud_cfg_if  cfg_if ();
	fud_res_if  res_if ();

	form_url_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.cfg     (cfg_if),
		.results (res_if)
	);

	fud_decode_monitor mon (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (chars_if.valid),
		.char_ready      (chars_if.ready),
		.char_kind       (chars_if.kind),
		.char_byte       (chars_if.in_byte),
		.cfg_valid       (cfg_if.valid),
		.cfg_ready       (cfg_if.ready),
		.cfg_size        (cfg_if.buffer_size),
		.res_valid       (res_if.valid),
		.res_ready       (res_if.ready),
		.res_byte        (res_if.out_byte),
		.res_has_byte    (res_if.has_byte),
		.res_last        (res_if.last),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Stall the result side at random
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(0, 99) >= sink_stall);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("[form_url_decoder] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_item(logic k, logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < src_idle) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.kind    <= k;
		chars_if.in_byte <= b;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i])
			send_item(KIND_CHAR, s[i]);
	endtask

	// Pause until every result is back and the block has settled
	task automatic drain();
		chars_if.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(logic [CFG_W-1:0] v);
		drain();
		cfg_if.valid       <= 1'b1;
		cfg_if.buffer_size <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] rand_hex();
		case ($urandom_range(0, 2))
			0: return BYTE_W'("0" + $urandom_range(0, 9));
			1: return BYTE_W'("a" + $urandom_range(0, 5));
			default: return BYTE_W'("A" + $urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] rand_nonhex();
		case ($urandom_range(0, 4))
			0: return BYTE_W'("g" + $urandom_range(0, 19));
			1: return CH_PLUS;
			2: return CH_PCT;
			3: return BYTE_W'($urandom_range(8'h80, 8'hFF));
			default: return BYTE_W'($urandom_range(8'h00, 8'h1F));
		endcase
	endfunction

	// One string of mixed segments, usually closed by an end item
	task automatic send_random_string();
		int segs;
		int pick;
		segs = $urandom_range(0, 12);
		repeat (segs) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_item(KIND_CHAR, BYTE_W'($urandom_range(8'h21, 8'h7E)));
			end else if (pick < 42) begin
				send_item(KIND_CHAR, CH_PLUS);
			end else if (pick < 50) begin
				send_item(KIND_CHAR, CH_SPACE);
			end else if (pick < 54) begin
				send_text("%20");
			end else if (pick < 57) begin
				send_text("%00");
			end else if (pick < 70) begin
				send_item(KIND_CHAR, CH_PCT);
				send_item(KIND_CHAR, rand_hex());
				send_item(KIND_CHAR, rand_hex());
			end else if (pick < 82) begin
				send_item(KIND_CHAR, CH_PCT);
				if ($urandom_range(0, 1))
					send_item(KIND_CHAR, rand_hex());
				if ($urandom_range(0, 2) != 0)
					send_item(KIND_CHAR, rand_nonhex());
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 20))
					send_item(KIND_CHAR, $urandom_range(0, 1) ? CH_SPACE : CH_PLUS);
			end else begin
				send_item(KIND_CHAR, BYTE_W'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_item(KIND_END, BYTE_W'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] sizes [12];
		int               target;
		chars_if.valid     = 1'b0;
		chars_if.kind      = KIND_CHAR;
		chars_if.in_byte   = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.buffer_size = '0;
		res_if.ready       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Escapes, broken escapes, zero bytes, trailing spaces, held escape at end
		send_text("A+b%41%4g%%20");
		send_item(KIND_CHAR, 8'h00);
		send_text("%00");
		send_item(KIND_CHAR, 8'hFF);
		send_text("+ ");
		send_item(KIND_END, 8'h00);
		send_text("%a");
		send_item(KIND_END, 8'hFF);
		send_item(KIND_END, 8'h00);

		// Random strings over a range of sizes and four idling phases
		sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd33,
			7'd65, 7'd5, 7'd3, 7'd10, 7'd63, 7'd0};
		sizes[11] = CFG_W'($urandom_range(1, 64));
		for (int i = 0; i < 12; i++) begin
			write_size(sizes[i]);
			case (i / 3)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 64; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 64; end
				default: begin src_idle = 13; sink_stall = 13; end
			endcase
			target = items_sent + ITEMS_PER_SETTING;
			while (items_sent < target)
				send_random_string();
			send_item(KIND_END, BYTE_W'($urandom_range(0, 255)));
		end

		drain();
		if (fail_count == 0)
			$display("[form_url_decoder] OK");
		else
			$display("[form_url_decoder] ERROR");
		$finish;
	end

endmodule
